### rtl/core/dcdc_pkg.sv
package dcdc_pkg;

  // Field widths of the request and result items.
  localparam int DAY_W    = 16;
  localparam int DATE_W   = 21;
  localparam int COUNT_W  = 17;
  localparam int PACKED_W = 19;

  // Number of pipeline stages in front of the result register.
  localparam int NSTAGE = 4;

  // Request modes.
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // Last valid day count (31 December 2079).
  localparam logic [DAY_W-1:0] MAX_DAY_COUNT = 16'd36525;

  // Reciprocals for the constant divisions (value times RECIP, shifted right by SHIFT).
  localparam logic [15:0] RECIP_1461  = 16'd45934;
  localparam int          SHIFT_1461  = 26;
  localparam logic [20:0] RECIP_10000 = 21'd1717987;
  localparam int          SHIFT_10000 = 34;
  localparam logic [13:0] RECIP_100   = 14'd10486;
  localparam int          SHIFT_100   = 20;

  // Load enables for the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Length of month mon (1 to 12); zero for any other code.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Day of year (from 0) on which the month with zero-based index idx starts.
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
  endfunction

  // Days before 1 January of year 1980 + y, over the leap-every-fourth-year rule.
  function automatic logic [15:0] year_start(input logic [6:0] y);
    logic [15:0] yw;
    yw = 16'(y);
    return 16'(yw * 16'd365) + 16'((yw + 16'd3) >> 2);
  endfunction

endpackage

### rtl/core/dcdc_in_if.sv
interface dcdc_in_if
  import dcdc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic        [DAY_W-1:0]  day_number;
  logic signed [DATE_W-1:0] packed_date;

  modport source (output valid, mode, day_number, packed_date, input ready);
  modport sink   (input valid, mode, day_number, packed_date, output ready);
endinterface

### rtl/core/dcdc_out_if.sv
interface dcdc_out_if
  import dcdc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] day_number_out;
  logic        [PACKED_W-1:0] packed_date_out;
  logic                      invalid;

  modport source (output valid, day_number_out, packed_date_out, invalid, input ready);
  modport sink   (input valid, day_number_out, packed_date_out, invalid, output ready);
endinterface

### rtl/core/day_count_date_converter_top.sv
// Day count / DDMMYY date converter.
//
// Requests arrive on in_chan with a ready/valid handshake. mode selects the
// direction: decode turns day_number (1 is 1 January 1980) into a decimal
// DDMMYY word, encode turns packed_date into a day count. Every request
// gives exactly one result on out_chan, in request order.
//
// A request passes the stage registers and then the result register.
// The pipeline takes a request in every cycle while out_chan.ready is
// high, so throughput is one request per cycle; the reciprocal multiplies
// for the constant divisions each own a stage and set the pipeline depth.
//
// Reset clears all stage valid bits and the result valid bit; payload and
// result data registers are not reset. When the receiver holds
// out_chan.ready low the result register holds, and empty stages still
// fill, so up to five requests are in flight before in_chan.ready falls.
module day_count_date_converter_top
  import dcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dcdc_in_if.sink    in_chan,
  dcdc_out_if.source out_chan
);

  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] mode_r;
  logic [NSTAGE-1:0] rdy;
  logic              rdy_out;
  logic              out_vld_r, out_vld_nxt;
  stage_en_t         en;

  logic signed [COUNT_W-1:0]  enc_count;
  logic                       enc_bad;
  logic        [PACKED_W-1:0] dec_packed;
  logic                       dec_bad;

  logic signed [COUNT_W-1:0]  out_count_r;
  logic        [PACKED_W-1:0] out_packed_r;
  logic                       out_invalid_r;

  // A stage can load when it is empty or its content moves on.
  assign rdy_out = !out_vld_r || out_chan.ready;

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || rdy_out;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign en.s1 = rdy[0] && in_chan.valid;
  assign en.s2 = rdy[1] && vld_r[0];
  assign en.s3 = rdy[2] && vld_r[1];
  assign en.s4 = rdy[3] && vld_r[2];

  // Valid bits move along with the data.
  always_comb begin
    vld_nxt[0] = rdy[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    out_vld_nxt = rdy_out ? vld_r[NSTAGE-1] : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // The request mode travels with each request.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      mode_r[0] <= in_chan.mode;
    end
    if (en.s2) begin
      mode_r[1] <= mode_r[0];
    end
    if (en.s3) begin
      mode_r[2] <= mode_r[1];
    end
    if (en.s4) begin
      mode_r[3] <= mode_r[2];
    end
  end

  dcdc_decode u_decode (
    .clk         (clk),
    .en          (en),
    .day_number  (in_chan.day_number),
    .packed_date (dec_packed),
    .bad         (dec_bad)
  );

  dcdc_encode u_encode (
    .clk         (clk),
    .en          (en),
    .packed_date (in_chan.packed_date),
    .day_count   (enc_count),
    .bad         (enc_bad)
  );

  // Result register: pick the path that the request's mode selects.
  always_ff @(posedge clk) begin
    if (rdy_out && vld_r[NSTAGE-1]) begin
      if (mode_r[NSTAGE-1] == MODE_ENCODE) begin
        out_count_r   <= enc_count;
        out_packed_r  <= '0;
        out_invalid_r <= enc_bad;
      end else begin
        out_count_r   <= '0;
        out_packed_r  <= dec_packed;
        out_invalid_r <= dec_bad;
      end
    end
  end

  assign in_chan.ready            = rdy[0];
  assign out_chan.valid           = out_vld_r;
  assign out_chan.day_number_out  = out_count_r;
  assign out_chan.packed_date_out = out_packed_r;
  assign out_chan.invalid         = out_invalid_r;

`ifndef ASSERT_OFF
  // An invalid result carries zero in both value fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_invalid_r |-> (out_count_r == '0) && (out_packed_r == '0))
    else $error("invalid result with nonzero value");

  // At most one of the two value fields is nonzero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_packed_r != '0) |-> (out_count_r == '0))
    else $error("both value fields nonzero");

  // An empty first stage always takes a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_chan.ready)
    else $error("request refused while first stage empty");

  // A new result only comes from the last pipeline stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(vld_r[NSTAGE-1]))
    else $error("result appeared without a request in the last stage");
`endif

endmodule

### rtl/core/dcdc_decode.sv
module dcdc_decode
  import dcdc_pkg::*;
(
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [DAY_W-1:0]    day_number,
  output logic [PACKED_W-1:0] packed_date,
  output logic                bad
);

  logic [DAY_W-1:0] dn_r;
  logic             bad2_r;
  logic [DAY_W-1:0] d2_r;
  logic [5:0]       q2_r;
  logic [6:0]       yy3_r;
  logic [8:0]       doy3_r;
  logic             leap3_r;
  logic             bad3_r;
  logic [3:0]       mon4_r;
  logic [4:0]       dom4_r;
  logic [6:0]       yy4_r;
  logic             bad4_r;

  logic [DAY_W-1:0] d_s2;
  logic [31:0]      qprod_s2;
  logic [DAY_W-1:0] rfull_s3;
  logic [10:0]      r_s3;
  logic [1:0]       yoff_s3;
  logic [10:0]      ofs_s3;
  logic [6:0]       y_s3;
  logic [3:0]       mon_s4;
  logic [8:0]       dom_s4;

  // Stage 1: capture the day count.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      dn_r <= day_number;
    end
  end

  // Stage 2: range check and four-year cycle number.
  assign d_s2     = dn_r - DAY_W'(1);
  assign qprod_s2 = 32'(d_s2) * 32'(RECIP_1461);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      bad2_r <= (dn_r == '0) || (dn_r > MAX_DAY_COUNT);
      d2_r   <= d_s2;
      q2_r   <= qprod_s2[SHIFT_1461 +: 6];
    end
  end

  // Stage 3: year within the cycle and day of year.
  assign rfull_s3 = d2_r - DAY_W'(17'(q2_r) * 17'd1461);
  assign r_s3     = rfull_s3[10:0];

  always_comb begin
    if (r_s3 >= 11'd1096) begin
      yoff_s3 = 2'd3;
      ofs_s3  = 11'd1096;
    end else if (r_s3 >= 11'd731) begin
      yoff_s3 = 2'd2;
      ofs_s3  = 11'd731;
    end else if (r_s3 >= 11'd366) begin
      yoff_s3 = 2'd1;
      ofs_s3  = 11'd366;
    end else begin
      yoff_s3 = 2'd0;
      ofs_s3  = 11'd0;
    end
  end

  assign y_s3 = 7'({q2_r[4:0], 2'b00}) + 7'(yoff_s3);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      yy3_r   <= (y_s3 < 7'd20) ? y_s3 + 7'd80 : y_s3 - 7'd20;
      doy3_r  <= 9'(r_s3 - ofs_s3);
      leap3_r <= (yoff_s3 == 2'd0);
      bad3_r  <= bad2_r;
    end
  end

  // Stage 4: month search over the month start table.
  always_comb begin
    mon_s4 = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy3_r >= month_start(4'(m), leap3_r)) begin
        mon_s4 = 4'(m);
      end
    end
  end

  assign dom_s4 = doy3_r - month_start(mon_s4, leap3_r);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      mon4_r <= mon_s4;
      dom4_r <= dom_s4[4:0];
      yy4_r  <= yy3_r;
      bad4_r <= bad3_r;
    end
  end

  // Assemble the decimal DDMMYY word.
  assign packed_date = bad4_r ? '0 :
                       PACKED_W'((19'(dom4_r) + 19'd1) * 19'd10000) +
                       PACKED_W'((19'(mon4_r) + 19'd1) * 19'd100) +
                       PACKED_W'(yy4_r);
  assign bad = bad4_r;

endmodule

### rtl/core/dcdc_encode.sv
module dcdc_encode
  import dcdc_pkg::*;
(
  input  logic                       clk,
  input  stage_en_t                  en,
  input  logic signed [DATE_W-1:0]   packed_date,
  output logic signed [COUNT_W-1:0]  day_count,
  output logic                       bad
);

  logic [DATE_W-1:0] pd_r;
  logic              pass2_r, neg2_r;
  logic [19:0]       v2_r;
  logic [6:0]        dd2_r;
  logic              pass3_r, neg3_r;
  logic [13:0]       rem3_r;
  logic [6:0]        dd3_r;
  logic              pass4_r, neg4_r;
  logic [13:0]       rem4_r;
  logic [6:0]        mm4_r;
  logic [6:0]        dd4_r;

  logic [40:0]       ddprod_s2;
  logic [19:0]       rem_s3;
  logic [27:0]       mmprod_s4;
  logic [13:0]       yysub;
  logic [6:0]        yy;
  logic              leap;
  logic              mm_ok, dd_ok;
  logic [3:0]        mon;
  logic [4:0]        maxd;
  logic [6:0]        y;
  logic [COUNT_W-1:0] days;

  // Stage 1: capture the date word.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      pd_r <= packed_date;
    end
  end

  // Stage 2: pass-through and sign checks, day digits.
  assign ddprod_s2 = 41'(pd_r[19:0]) * 41'(RECIP_10000);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pass2_r <= &pd_r;
      neg2_r  <= pd_r[DATE_W-1];
      v2_r    <= pd_r[19:0];
      dd2_r   <= ddprod_s2[SHIFT_10000 +: 7];
    end
  end

  // Stage 3: remainder after the day digits.
  assign rem_s3 = v2_r - 20'(20'(dd2_r) * 20'd10000);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pass3_r <= pass2_r;
      neg3_r  <= neg2_r;
      rem3_r  <= rem_s3[13:0];
      dd3_r   <= dd2_r;
    end
  end

  // Stage 4: month digits.
  assign mmprod_s4 = 28'(rem3_r) * 28'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      pass4_r <= pass3_r;
      neg4_r  <= neg3_r;
      rem4_r  <= rem3_r;
      mm4_r   <= mmprod_s4[SHIFT_100 +: 7];
      dd4_r   <= dd3_r;
    end
  end

  // Year digits, field checks and the day count sum.
  assign yysub = rem4_r - 14'(14'(mm4_r) * 14'd100);
  assign yy    = yysub[6:0];
  assign leap  = (yy[1:0] == 2'b00);
  assign mm_ok = (mm4_r >= 7'd1) && (mm4_r <= 7'd12);
  assign mon   = mm4_r[3:0];
  assign maxd  = month_len(mon, leap);
  assign dd_ok = (dd4_r != 7'd0) && (dd4_r <= 7'(maxd));
  assign y     = (yy < 7'd80) ? yy + 7'd20 : yy - 7'd80;
  assign days  = COUNT_W'(year_start(y)) +
                 COUNT_W'(month_start(mon - 4'd1, leap)) +
                 COUNT_W'(dd4_r);

  always_comb begin
    if (pass4_r) begin
      day_count = '1;
      bad       = 1'b0;
    end else if (neg4_r || !mm_ok || !dd_ok) begin
      day_count = '0;
      bad       = 1'b1;
    end else begin
      day_count = days;
      bad       = 1'b0;
    end
  end

endmodule
